@@ hw/rtl/sha256_pair_state_distance_defines.svh @@
// ----------------------------------------------------------------------------
// SHA-256 pair state distance: assertion macros
// Shared concurrent assertion forms, clocked on clk_i; one is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SHA256_PAIR_STATE_DISTANCE_DEFINES_SVH
`define SHA256_PAIR_STATE_DISTANCE_DEFINES_SVH

// Checked only while the block is out of reset.
`define SPSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SPSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/spsd_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 pair state distance: package
// Constants, command type and SHA-256 helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spsd_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned DistW      = 9;
  localparam int unsigned RoundIdxW  = 6;
  localparam int unsigned WordCntW   = 4;
  localparam int unsigned SchedDepth = 16;
  localparam int unsigned StateDepth = 8;
  localparam int unsigned PopW       = 6;
  localparam int unsigned DefaultRounds = 64;

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WordW-1:0] InitValue [StateDepth] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Datapath commands issued by the controller, one cycle each.
  typedef struct packed {
    logic                 load;     // shift a word pair into the schedules
    logic                 init;     // load the initial value, clear the sum
    logic                 round;    // run one compression round
    logic [RoundIdxW-1:0] k_idx;    // round constant for that round
    logic                 count;    // add one word pair of the state distance
    logic                 publish;  // copy the sum to the result register
  } cmd_t;

  function automatic logic [WordW-1:0] rotr32(logic [WordW-1:0] x, int unsigned n);
    logic [2*WordW-1:0] both;
    both = {x, x} >> n;
    return both[WordW-1:0];
  endfunction

  function automatic logic [WordW-1:0] big_sigma0(logic [WordW-1:0] x);
    return rotr32(x, 2) ^ rotr32(x, 13) ^ rotr32(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(logic [WordW-1:0] x);
    return rotr32(x, 6) ^ rotr32(x, 11) ^ rotr32(x, 25);
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(logic [WordW-1:0] x);
    return rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(logic [WordW-1:0] x);
    return rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [PopW-1:0] popcount32(logic [WordW-1:0] x);
    logic [PopW-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < WordW; i++) begin
      cnt = cnt + PopW'(x[i]);
    end
    return cnt;
  endfunction

endpackage

@@ hw/rtl/spsd_lane.sv @@
// ----------------------------------------------------------------------------
// SHA-256 pair state distance: compression lane
// Schedule window and working state of one block, one round per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spsd_lane import spsd_pkg::*; (
  input  logic             clk_i,
  input  cmd_t             cmd_i,
  input  logic [WordW-1:0] word_i,
  output logic [WordW-1:0] tap_o
);

  logic [WordW-1:0] sched_q [SchedDepth];
  logic [WordW-1:0] sched_d [SchedDepth];
  logic [WordW-1:0] work_q  [StateDepth];
  logic [WordW-1:0] work_d  [StateDepth];
  logic [WordW-1:0] w_next;
  logic [WordW-1:0] t1;
  logic [WordW-1:0] t2;
  logic [WordW-1:0] ch;
  logic [WordW-1:0] maj;

  // Entry 0 is the word of the current round; the word sixteen rounds
  // ahead is shifted in at the top, so the window always holds W[r..r+15].
  assign w_next = small_sigma1(sched_q[14]) + sched_q[9]
                + small_sigma0(sched_q[1]) + sched_q[0];

  assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2])
             ^ (work_q[1] & work_q[2]);
  assign t1  = work_q[7] + big_sigma1(work_q[4]) + ch + RoundK[cmd_i.k_idx]
             + sched_q[0];
  assign t2  = big_sigma0(work_q[0]) + maj;

  always_comb begin
    sched_d = sched_q;
    priority if (cmd_i.load) begin
      for (int i = 0; i < SchedDepth - 1; i++) sched_d[i] = sched_q[i+1];
      sched_d[SchedDepth-1] = word_i;
    end else if (cmd_i.round) begin
      for (int i = 0; i < SchedDepth - 1; i++) sched_d[i] = sched_q[i+1];
      sched_d[SchedDepth-1] = w_next;
    end else begin
      sched_d = sched_q;
    end
  end

  always_comb begin
    work_d = work_q;
    priority if (cmd_i.init) begin
      work_d = InitValue;
    end else if (cmd_i.round) begin
      work_d[0] = t1 + t2;
      work_d[1] = work_q[0];
      work_d[2] = work_q[1];
      work_d[3] = work_q[2];
      work_d[4] = work_q[3] + t1;
      work_d[5] = work_q[4];
      work_d[6] = work_q[5];
      work_d[7] = work_q[6];
    end else if (cmd_i.count) begin
      // Rotate so that every word passes the tap once during the distance count.
      for (int i = 1; i < StateDepth; i++) work_d[i] = work_q[i-1];
      work_d[0] = work_q[StateDepth-1];
    end else begin
      work_d = work_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sched_q <= sched_d;
    work_q  <= work_d;
  end

  assign tap_o = work_q[StateDepth-1];

endmodule

@@ hw/rtl/spsd_dpath.sv @@
// ----------------------------------------------------------------------------
// SHA-256 pair state distance: datapath
// Two compression lanes and the word-serial distance accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spsd_dpath import spsd_pkg::*; (
  input  logic             clk_i,
  input  cmd_t             cmd_i,
  input  logic [WordW-1:0] word_a_i,
  input  logic [WordW-1:0] word_b_i,
  output logic [DistW-1:0] distance_o
);

  logic [WordW-1:0] tap_a;
  logic [WordW-1:0] tap_b;
  logic [DistW-1:0] acc_q;
  logic [DistW-1:0] acc_d;
  logic [DistW-1:0] dist_q;
  logic [DistW-1:0] dist_d;

  spsd_lane u_lane_a (
    .clk_i  (clk_i),
    .cmd_i  (cmd_i),
    .word_i (word_a_i),
    .tap_o  (tap_a)
  );

  spsd_lane u_lane_b (
    .clk_i  (clk_i),
    .cmd_i  (cmd_i),
    .word_i (word_b_i),
    .tap_o  (tap_b)
  );

  always_comb begin
    priority if (cmd_i.init) begin
      acc_d = '0;
    end else if (cmd_i.count) begin
      acc_d = acc_q + DistW'(popcount32(tap_a ^ tap_b));
    end else begin
      acc_d = acc_q;
    end
  end

  assign dist_d = cmd_i.publish ? acc_q : dist_q;

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    dist_q <= dist_d;
  end

  assign distance_o = dist_q;

endmodule

@@ hw/rtl/spsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// SHA-256 pair state distance: controller
// Sequences word loading, compression rounds, distance count and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spsd_ctrl import spsd_pkg::*; #(
  parameter int unsigned ROUNDS = DefaultRounds
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StLoad  = 4'b0001,
    StRound = 4'b0010,
    StCount = 4'b0100,
    StHold  = 4'b1000
  } state_e;

  localparam logic [RoundIdxW-1:0] LastRound = RoundIdxW'(ROUNDS - 1);
  localparam logic [WordCntW-1:0]  LastWord  = WordCntW'(SchedDepth - 1);
  localparam logic [2:0]           LastCount = 3'(StateDepth - 1);

  state_e               state_q, state_d;
  logic [WordCntW-1:0]  word_q, word_d;
  logic [RoundIdxW-1:0] round_q, round_d;
  logic [2:0]           cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    round_d     = round_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.k_idx = round_q;
    unique case (state_q)
      StLoad: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (word_q == LastWord) begin
            cmd_o.init = 1'b1;
            word_d     = '0;
            round_d    = '0;
            state_d    = StRound;
          end else begin
            word_d = word_q + WordCntW'(1);
          end
        end
      end
      StRound: begin
        cmd_o.round = 1'b1;
        if (round_q == LastRound) begin
          cnt_d   = '0;
          state_d = StCount;
        end else begin
          round_d = round_q + RoundIdxW'(1);
        end
      end
      StCount: begin
        cmd_o.count = 1'b1;
        cnt_d       = cnt_q + 3'd1;
        if (cnt_q == LastCount) state_d = StHold;
      end
      StHold: begin
        // Wait until the result register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.publish) out_valid_d = 1'b1;
    else if (out_ready_i)       out_valid_d = 1'b0;
    else                        out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      word_q      <= '0;
      round_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      round_q     <= round_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/sha256_pair_state_distance.sv @@
// ----------------------------------------------------------------------------
// SHA-256 pair state distance
// Compresses two message blocks from the SHA-256 initial value and reports
// the Hamming distance between the two final working states.
// ----------------------------------------------------------------------------
// A block pair arrives as sixteen items, word 0 first, one word of each block
// per item, taken at up to one item per cycle. After the sixteenth item the
// input is closed while each lane runs ROUNDS compression rounds, one round
// per cycle, the distance is then summed one word pair per cycle, and the
// hold state moves it to the result register once that register is free or
// being emptied; only then does the input open for the next pair. The result
// register lets the next pair load while a result waits to be taken.
`timescale 1ns / 1ps
`include "sha256_pair_state_distance_defines.svh"

module sha256_pair_state_distance import spsd_pkg::*; #(
  parameter int unsigned ROUNDS = DefaultRounds
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WordW-1:0] word_a_i,
  input  logic [WordW-1:0] word_b_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DistW-1:0] distance_o
);

  cmd_t cmd;

  spsd_ctrl #(
    .ROUNDS (ROUNDS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  spsd_dpath u_dpath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .word_a_i   (word_a_i),
    .word_b_i   (word_b_i),
    .distance_o (distance_o)
  );

  `SPSD_ASSERT(a_cmd_exclusive, $onehot0({cmd.init, cmd.round, cmd.count, cmd.publish}), "datapath commands overlap")
  `SPSD_ASSERT(a_no_load_in_round, cmd.round |-> !in_ready_o, "input open during compression")
  `SPSD_ASSERT(a_publish_valid, cmd.publish |=> out_valid_o, "published result not presented")
  `SPSD_ASSERT_ALWAYS(a_dist_range, out_valid_o |-> (distance_o <= 9'd256), "distance out of range")

endmodule

@@ tb/sv/tb_sha256_pair_state_distance.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 pair state distance: testbench
// Sends block pairs one word pair per item, predicts the Hamming distance
// between the two unfinished SHA-256 working states, and checks each result.
// ----------------------------------------------------------------------------

module tb_sha256_pair_state_distance;
  import spsd_pkg::*;

  typedef logic [31:0] msg_block_t [16];

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 150;
  localparam int unsigned PairsPerPhase = 20;

  // Holds the word pairs of the pair being loaded and the distances still owed.
  class pair_distance_board;
    logic [31:0] round_const [64];
    logic [31:0] start_state [8];
    logic [31:0] held_a [16];
    logic [31:0] held_b [16];
    int unsigned words_held;
    logic [8:0]  expected_distances [$];
    int unsigned fail_count;

    function new();
      round_const = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
      };
      start_state = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
      };
      words_held = 0;
      fail_count = 0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Schedule expansion and all rounds, without the final feed-forward add.
    function logic [255:0] compress_block(msg_block_t msg);
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int r = 0; r < 16; r++) w[r] = msg[r];
      for (int r = 16; r < 64; r++) begin
        w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
             + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
      end
      a = start_state[0]; b = start_state[1]; c = start_state[2]; d = start_state[3];
      e = start_state[4]; f = start_state[5]; g = start_state[6]; h = start_state[7];
      for (int r = 0; r < 64; r++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + round_const[r] + w[r];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      return {a, b, c, d, e, f, g, h};
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      fail_count++;
    endtask

    task note_pair_word(logic [31:0] a, logic [31:0] b);
      held_a[words_held] = a;
      held_b[words_held] = b;
      if (words_held == 15) begin
        expected_distances.push_back(
          9'($countones(compress_block(held_a) ^ compress_block(held_b))));
        words_held = 0;
      end else begin
        words_held++;
      end
    endtask

    task check_distance(logic [8:0] got);
      logic [8:0] want;
      if (expected_distances.size() == 0) begin
        report_mismatch($sformatf("distance %0d with no block pair pending", got));
      end else begin
        want = expected_distances.pop_front();
        if (got !== want)
          report_mismatch($sformatf("distance %0d, expected %0d", got, want));
      end
    endtask

    task flush_leftover();
      while (expected_distances.size() != 0)
        report_mismatch($sformatf("distance %0d never delivered",
                                  expected_distances.pop_front()));
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [WordW-1:0] word_a_i = '0;
  logic [WordW-1:0] word_b_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [DistW-1:0] distance_o;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  pair_distance_board sb = new();

  sha256_pair_state_distance dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .word_a_i    (word_a_i),
    .word_b_i    (word_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .distance_o  (distance_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i = (rcv_idle_pct == 0) || ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_pair_word(word_a_i, word_b_i);
      if (out_valid_o && out_ready_i) sb.check_distance(distance_o);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  task send_word_pair(logic [31:0] a, logic [31:0] b);
    @(negedge clk_i);
    // Each cycle before the item is offered idles with the given chance.
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    word_a_i   = a;
    word_b_i   = b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task send_block_pair(msg_block_t blk_a, msg_block_t blk_b);
    for (int i = 0; i < 16; i++) send_word_pair(blk_a[i], blk_b[i]);
  endtask

  // Mix of unrelated, equal, nearly equal, sparse, complementary and partly
  // all-zero or all-ones blocks so that the distance varies widely, zero included.
  task make_block_pair(output msg_block_t blk_a, output msg_block_t blk_b);
    int unsigned kind;
    int unsigned pick;
    kind = $urandom_range(99);
    for (int i = 0; i < 16; i++) begin
      blk_a[i] = $urandom;
      blk_b[i] = $urandom;
    end
    if (kind < 40) begin
      // Unrelated blocks, already set up.
    end else if (kind < 55) begin
      blk_b = blk_a;
    end else if (kind < 75) begin
      blk_b = blk_a;
      pick = $urandom_range(15);
      blk_b[pick][$urandom_range(31)] ^= 1'b1;
    end else if (kind < 88) begin
      for (int i = 0; i < 16; i++) begin
        blk_a[i] = $urandom & $urandom & $urandom;
        blk_b[i] = $urandom & $urandom & $urandom;
      end
    end else if (kind < 95) begin
      for (int i = 0; i < 16; i++) blk_b[i] = ~blk_a[i];
    end else begin
      for (int i = 0; i < 16; i++) begin
        pick = $urandom_range(2);
        blk_a[i] = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffffffff : blk_a[i];
        pick = $urandom_range(2);
        blk_b[i] = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffffffff : blk_b[i];
      end
    end
  endtask

  initial begin
    msg_block_t blk_a;
    msg_block_t blk_b;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    snd_idle_pct = 14;
    rcv_idle_pct = 47;
    // Extreme words, swapped between the lanes from one word to the next.
    for (int i = 0; i < 16; i++) begin
      blk_a[i] = (i % 2 == 0) ? 32'h0 : 32'hffffffff;
      blk_b[i] = ~blk_a[i];
    end
    send_block_pair(blk_a, blk_b);

    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 47 : 0;
      rcv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 14 : 0;
      for (int p = 0; p < PairsPerPhase; p++) begin
        make_block_pair(blk_a, blk_b);
        send_block_pair(blk_a, blk_b);
      end
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (sb.expected_distances.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    sb.flush_leftover();

    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/spsd_pkg.sv
hw/rtl/spsd_lane.sv
hw/rtl/spsd_dpath.sv
hw/rtl/spsd_ctrl.sv
hw/rtl/sha256_pair_state_distance.sv
tb/sv/tb_sha256_pair_state_distance.sv
